>>> design/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

   // Width of the length registers and of the replacement byte index
   localparam int LEN_W       = 4;
   localparam int BYTE_W      = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LENGTH     = 2'd0,
      CSR_PATTERN_BYTES      = 2'd1,
      CSR_REPLACEMENT_LENGTH = 2'd2,
      CSR_REPLACEMENT_BYTES  = 2'd3
   } csr_index_type;

   // Source of the result beat loaded this cycle
   typedef enum logic [1:0] {
      EMIT_NONE = 2'd0,
      EMIT_WIN  = 2'd1,
      EMIT_REP  = 2'd2,
      EMIT_MARK = 2'd3
   } emit_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic               load;      // take the input beat into the window
      emit_sel_type       emit_sel;  // what goes into the result register
      logic               last;      // result closes the text
      logic               drop_one;  // shift the window down by one byte
      logic               clear;     // empty the window
      logic [LEN_W-1:0]   rep_idx;   // replacement byte to send
   } sfr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic               empty;     // window holds no byte
      logic               one_left;  // window holds exactly one byte
      logic               prefix;    // window agrees with the pattern so far
      logic               match;     // window holds the whole pattern
      logic               out_free;  // result register can take a beat
      logic [LEN_W-1:0]   rep_len;   // clamped replacement length
   } sfr_status_type;

endpackage

`default_nettype wire

>>> design/sfr_ctrl.sv
`default_nettype none

module sfr_ctrl
   import sfr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_final_byte,
   output logic                req_stall,
   input  wire sfr_status_type status,
   output sfr_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_REPL = 3'b100
   } sfr_state_type;

   sfr_state_type    state_ff, state_in;
   logic             fin_ff, fin_in;
   logic             sent_ff, sent_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             rep_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign rep_last  = (idx_ff == status.rep_len - LEN_W'(1));

   // Sequence one text beat: take it, scan the window, send replacement
   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      sent_in      = sent_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.emit_sel = EMIT_NONE;
      cmd.rep_idx  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               fin_in   = req_final_byte;
               sent_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.empty) begin
               // close the text with a marker when nothing went out
               if (fin_ff && !sent_ff) begin
                  if (status.out_free) begin
                     cmd.emit_sel = EMIT_MARK;
                     cmd.last     = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (status.match) begin
               if (status.rep_len == '0) begin
                  cmd.clear = 1'b1;
               end else begin
                  idx_in   = '0;
                  state_in = ST_REPL;
               end
            end else if (status.prefix && !fin_ff) begin
               // hold the partial match for the next beat
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               // release the oldest byte; at the end this flushes
               cmd.emit_sel = EMIT_WIN;
               cmd.last     = fin_ff && status.one_left;
               cmd.drop_one = 1'b1;
               sent_in      = 1'b1;
            end
         end
         ST_REPL: begin
            if (status.out_free) begin
               cmd.emit_sel = EMIT_REP;
               cmd.last     = fin_ff && rep_last;
               sent_in      = 1'b1;
               if (rep_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  idx_in = idx_ff + LEN_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         sent_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         sent_ff  <= sent_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> design/sfr_dpath.sv
`default_nettype none

module sfr_dpath
   import sfr_pkg::*;
#(
   parameter int PATTERN_MAX     = 8,
   parameter int REPLACEMENT_MAX = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [BYTE_W-1:0]      req_text_byte,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic [BYTE_W-1:0]           rsp_out_byte,
   output logic                        rsp_end_of_text,
   output logic                        rsp_empty_marker,
   input  wire sfr_cmd_type            cmd,
   output sfr_status_type              status
);

   localparam int CNT_W = $clog2(PATTERN_MAX + 1);
   localparam int PAT_W = PATTERN_MAX * BYTE_W;
   localparam int REP_W = REPLACEMENT_MAX * BYTE_W;

   // Configuration registers
   logic [LEN_W-1:0] pat_len_ff;
   logic [PAT_W-1:0] pat_bytes_ff;
   logic [LEN_W-1:0] rep_len_ff;
   logic [REP_W-1:0] rep_bytes_ff;

   // Active pattern, window and result register
   logic [CNT_W-1:0]  act_len_ff, act_len_in;
   logic [PAT_W-1:0]  act_bytes_ff, act_bytes_in;
   logic [BYTE_W-1:0] win_ff [PATTERN_MAX];
   logic [BYTE_W-1:0] win_in [PATTERN_MAX];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_end_ff, out_end_in;
   logic              out_mark_ff, out_mark_in;

   logic [CNT_W-1:0]      pat_len_clamp;
   logic [LEN_W-1:0]      rep_len_clamp;
   logic [CNT_W-1:0]      cmp_n;
   logic [PATTERN_MAX-1:0] miss;
   logic [BYTE_W-1:0]     rep_byte;
   logic                  out_free;

   // Write configuration; keep only the bytes the window can use
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff   <= LEN_W'(1);
         pat_bytes_ff <= '0;
         rep_len_ff   <= '0;
         rep_bytes_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PATTERN_LENGTH:     pat_len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_PATTERN_BYTES:      pat_bytes_ff <= csr_wdata[PAT_W-1:0];
            CSR_REPLACEMENT_LENGTH: rep_len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  rep_bytes_ff <= csr_wdata[REP_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp lengths into their legal ranges
   always_comb begin
      if (pat_len_ff == '0) begin
         pat_len_clamp = CNT_W'(1);
      end else if (pat_len_ff > LEN_W'(PATTERN_MAX)) begin
         pat_len_clamp = CNT_W'(PATTERN_MAX);
      end else begin
         pat_len_clamp = pat_len_ff[CNT_W-1:0];
      end
      if (rep_len_ff > LEN_W'(REPLACEMENT_MAX)) begin
         rep_len_clamp = LEN_W'(REPLACEMENT_MAX);
      end else begin
         rep_len_clamp = rep_len_ff;
      end
   end

   // Compare the window with the pattern over the shorter of the two
   always_comb begin
      cmp_n = (cnt_ff < act_len_ff) ? cnt_ff : act_len_ff;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         miss[i] = (CNT_W'(i) < cmp_n) && (win_ff[i] != act_bytes_ff[i*BYTE_W +: BYTE_W]);
      end
   end

   // Pick the replacement byte to send
   always_comb begin
      rep_byte = '0;
      for (int j = 0; j < REPLACEMENT_MAX; j++) begin
         if (cmd.rep_idx == LEN_W'(j)) begin
            rep_byte = rep_bytes_ff[j*BYTE_W +: BYTE_W];
         end
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      status.empty    = (cnt_ff == '0);
      status.one_left = (cnt_ff == CNT_W'(1));
      status.prefix   = ~|miss;
      status.match    = ~|miss && (cnt_ff >= act_len_ff);
      status.out_free = out_free;
      status.rep_len  = rep_len_clamp;
   end

   // Window: append (taking the active pattern when empty), drop the oldest byte, or empty it
   always_comb begin
      act_len_in   = act_len_ff;
      act_bytes_in = act_bytes_ff;
      cnt_in       = cnt_ff;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         win_in[i] = win_ff[i];
      end
      if (cmd.load) begin
         if (cnt_ff == '0) begin
            act_len_in   = pat_len_clamp;
            act_bytes_in = pat_bytes_ff;
         end
         for (int i = 0; i < PATTERN_MAX; i++) begin
            if (cnt_ff == CNT_W'(i)) begin
               win_in[i] = req_text_byte;
            end
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.clear) begin
         cnt_in = '0;
      end else if (cmd.drop_one) begin
         for (int i = 0; i < PATTERN_MAX - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // Result register: load a beat when free, drop it once taken
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_mark_in  = out_mark_ff;
      case (cmd.emit_sel)
         EMIT_WIN: begin
            out_valid_in = 1'b1;
            out_byte_in  = win_ff[0];
            out_end_in   = cmd.last;
            out_mark_in  = 1'b0;
         end
         EMIT_REP: begin
            out_valid_in = 1'b1;
            out_byte_in  = rep_byte;
            out_end_in   = cmd.last;
            out_mark_in  = 1'b0;
         end
         EMIT_MARK: begin
            out_valid_in = 1'b1;
            out_byte_in  = '0;
            out_end_in   = 1'b1;
            out_mark_in  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_len_ff   <= CNT_W'(1);
         act_bytes_ff <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         act_len_ff   <= act_len_in;
         act_bytes_ff <= act_bytes_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         win_ff[i] <= win_in[i];
      end
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_mark_ff <= out_mark_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_end_of_text  = out_end_ff;
   assign rsp_empty_marker = out_mark_ff;

endmodule

`default_nettype wire

>>> design/stream_find_and_replace.sv
// A beat is written into the window, scanned in ST_SCAN and loaded into the result register
//   that drives the outputs; a match with a nonempty replacement goes through ST_REPL first.
// The block takes a beat only in ST_IDLE (req_stall is high otherwise); the scan then fills
//   the one result register a byte per cycle while it is free, and closes with a step that
//   carries any end marker. Reset (synchronous, active high) empties the window, drops
//   any result and loads the defaults: pattern length 1, all else zero.
`default_nettype none

module stream_find_and_replace
   import sfr_pkg::*;
#(
   parameter int PATTERN_MAX     = 8,
   parameter int REPLACEMENT_MAX = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [BYTE_W-1:0]      req_text_byte,
   input  wire logic                   req_final_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [BYTE_W-1:0]           rsp_out_byte,
   output logic                        rsp_end_of_text,
   output logic                        rsp_empty_marker
);

   sfr_cmd_type    cmd;
   sfr_status_type status;

   sfr_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_byte (req_final_byte),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   sfr_dpath #(
      .PATTERN_MAX     (PATTERN_MAX),
      .REPLACEMENT_MAX (REPLACEMENT_MAX)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_text_byte    (req_text_byte),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_end_of_text  (rsp_end_of_text),
      .rsp_empty_marker (rsp_empty_marker),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire
